// File: hdl/wrcm_pkg.sv
// ----------------------------------------------------------------------------
// wrcm_pkg
// Shared types, constants and fixed-point helpers for the confidence monitor.
// ----------------------------------------------------------------------------
package wrcm_pkg;

  localparam logic [63:0] SMAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;

  // configuration register indexes
  localparam logic [2:0] CFG_ENABLED     = 3'd0;
  localparam logic [2:0] CFG_TARGET      = 3'd1;
  localparam logic [2:0] CFG_RELATIVE    = 3'd2;
  localparam logic [2:0] CFG_MIN_SAMPLES = 3'd3;
  localparam logic [2:0] CFG_MIN_TIME    = 3'd4;
  localparam logic [2:0] CFG_QUANTILE    = 3'd5;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    logic      start;
    arith_op_e op;
  } arith_req_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD, ST_LD,
    ST_M1_GO, ST_M1, ST_D1_GO, ST_D1,
    ST_M2_GO, ST_M2, ST_D2_GO, ST_D2,
    ST_M3_GO, ST_M3, ST_D3_GO, ST_D3,
    ST_S1_GO, ST_S1, ST_D4_GO, ST_D4,
    ST_S2_GO, ST_S2, ST_M4_GO, ST_M4,
    ST_M5_GO, ST_M5, ST_FIN
  } seq_state_e;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // magnitude plus sign back to a saturated signed value
  function automatic logic [63:0] signed_of(input logic neg, input logic [63:0] m);
    if (!neg) return (m > SMAX) ? SMAX : m;
    return (m > SMIN) ? SMIN : (64'd0 - m);
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
    return r;
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
    return r;
  endfunction

  // low 64 bits, clamped to all ones if anything above is set
  function automatic logic [63:0] sat_lo(input logic [127:0] x);
    return (x[127:64] != 64'd0) ? {64{1'b1}} : x[63:0];
  endfunction

  // bits 95:32 (drop 32 fraction bits), clamped
  function automatic logic [63:0] sat_hi(input logic [127:0] x);
    return (x[127:96] != 32'd0) ? {64{1'b1}} : x[95:32];
  endfunction

endpackage

// File: hdl/wrcm_arith.sv
// ----------------------------------------------------------------------------
// wrcm_arith
// Shared iterative unit: 64x64 multiply (four 32x32 partial products),
// 128/64 restoring divide (one bit a cycle), 128-bit square root (one
// root bit a cycle).
// ----------------------------------------------------------------------------
module wrcm_arith (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wrcm_pkg::arith_req_t   req_i,
  input  logic [127:0]           a_i,    // mul: low 64 bits; div: dividend; sqrt: radicand
  input  logic [63:0]            b_i,    // mul: multiplier; div: divisor
  output logic                   done_o,
  output logic [127:0]           res_o
);
  import wrcm_pkg::*;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  arith_op_e     op_q, op_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [127:0]  acc_q, acc_d;
  logic [65:0]   rem_q, rem_d;
  logic [63:0]   root_q, root_d;
  logic [63:0]   a_q, a_d;
  logic [63:0]   b_q, b_d;

  logic [31:0]   ah, bh;
  logic [63:0]   pp;
  logic [127:0]  pp_sh;
  logic [64:0]   div_rs;
  logic          div_ge;
  logic [67:0]   sq_rs, sq_tr, sq_diff;
  logic          sq_ge;
  logic [6:0]    last;

  always_comb begin
    ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp = ah * bh;
    case (cnt_q[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    div_rs  = {rem_q[63:0], acc_q[127]};
    div_ge  = div_rs >= {1'b0, b_q};
    sq_rs   = {rem_q, acc_q[127:126]};
    sq_tr   = {2'b00, root_q, 2'b01};
    sq_ge   = sq_rs >= sq_tr;
    sq_diff = sq_rs - sq_tr;
    case (op_q)
      OP_MUL:  last = 7'd3;
      OP_DIV:  last = 7'd127;
      default: last = 7'd63;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    root_d = root_q;
    a_d    = a_q;
    b_d    = b_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = 7'd0;
      a_d    = a_i[63:0];
      b_d    = b_i;
      acc_d  = (req_i.op == OP_MUL) ? 128'd0 : a_i;
      rem_d  = 66'd0;
      root_d = 64'd0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 7'd1;
      case (op_q)
        OP_MUL: begin
          acc_d = acc_q + pp_sh;
        end
        OP_DIV: begin
          rem_d = div_ge ? {2'b00, div_rs[63:0] - b_q} : {1'b0, div_rs};
          acc_d = {acc_q[126:0], div_ge};
        end
        OP_SQRT: begin
          rem_d  = sq_ge ? sq_diff[65:0] : sq_rs[65:0];
          root_d = {root_q[62:0], sq_ge};
          acc_d  = {acc_q[125:0], 2'b00};
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
      if (cnt_q == last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OP_MUL;
      cnt_q  <= 7'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    a_q    <= a_d;
    b_q    <= b_d;
  end

  assign done_o = done_q;
  assign res_o  = (op_q == OP_SQRT) ? {64'd0, root_q} : acc_q;

endmodule

// File: hdl/weighted_running_confidence_monitor.sv
// ----------------------------------------------------------------------------
// weighted_running_confidence_monitor
// Per-channel time-weighted running mean, variance and confidence half-width
// with convergence verdicts, in signed Q32.32.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat contents
//  --------  ---  ---------------------------------------------------------
//  s_axis    in   channel, sample_value, time_step; tuser = first_in_step
//  m_axis    out  running_mean_out, std_deviation, confidence_halfwidth;
//                 tuser = channel_converged, step_converged
//  cfg       in   write enable, register index, 48-bit data; no read-back
//
//  An enabled sample runs its multiplies, square roots and divides (up to
//  four divides) one after another on the shared iterative unit, each
//  issued from its own start state, between the accept, read, load and
//  finish steps. A disabled sample goes from load straight to finish.
//  s_axis_tready is high only while the sequencer is idle; a finished beat
//  waits in the output register, and the next sample is taken meanwhile.
//  Reset clears all channel statistics (per-channel valid bits) at once.
//
module weighted_running_confidence_monitor #(
  parameter int CHANNELS = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [2:0]     cfg_idx_i,
  input  logic [47:0]    cfg_wdata_i,
  input  logic           s_axis_tvalid,
  output logic           s_axis_tready,
  input  logic [119:0]   s_axis_tdata,  // channel[2:0], sample_value[66:3], time_step[114:67]
  input  logic           s_axis_tuser,  // first_in_step
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [191:0]   m_axis_tdata,  // running_mean_out[63:0], std_deviation[126:64],
                                        // confidence_halfwidth[189:127]
  output logic [1:0]     m_axis_tuser   // channel_converged[0], step_converged[1]
);
  import wrcm_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MW = 224;  // n(32) t(64) mean(64) ssd(64)

  // channel number wrapped into range
  function automatic logic [CW-1:0] ch_wrap(input logic [2:0] c);
    int v;
    v = int'(c);
    for (int i = 0; i < 8; i++) begin
      if (v >= CHANNELS) v = v - CHANNELS;
    end
    return CW'(v);
  endfunction

  // configuration
  logic          enabled_q;
  logic [47:0]   target_q;
  logic          relative_q;
  logic [31:0]   min_samples_q;
  logic [47:0]   min_time_q;
  logic [47:0]   quantile_q;

  seq_state_e    state_q, state_d;

  // per-sample working registers
  logic [CW-1:0] ch_q;
  logic [63:0]   x_q;
  logic [47:0]   dt_q;
  logic          first_q;
  logic [31:0]   n_q, n_d;
  logic [63:0]   t_q, t_d;
  logic [63:0]   mean_q, mean_d;
  logic [63:0]   ssd_q, ssd_d;
  logic [63:0]   dx_q, dx_d;
  logic [63:0]   p1_q, p1_d;
  logic [63:0]   var_q, var_d;
  logic [63:0]   std_q, std_d;
  logic [63:0]   se_q, se_d;
  logic [63:0]   hw_q, hw_d;
  logic [63:0]   tol_q, tol_d;
  logic [127:0]  prod_q, prod_d;
  logic          flag_q, flag_d;

  // output register
  logic          m_valid_q, m_valid_d;
  logic [191:0]  m_data_q, m_data_d;
  logic [1:0]    m_user_q, m_user_d;

  // channel statistics memory
  logic [MW-1:0]       mem [CHANNELS];
  logic [MW-1:0]       rd_q;
  logic [CHANNELS-1:0] valid_q;
  logic                mem_we;
  logic [MW-1:0]       mem_wdata;

  // shared unit
  arith_req_t    req;
  logic [127:0]  arith_a;
  logic [63:0]   arith_b;
  logic          arith_done;
  logic [127:0]  arith_res;

  logic [63:0]   dx_c, e_c, ssd_new, hval;
  logic          var_go, out_free, fin_load, conv;
  logic [31:0]   minn;
  logic [64:0]   t_sum;

  wrcm_arith u_arith (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .a_i    (arith_a),
    .b_i    (arith_b),
    .done_o (arith_done),
    .res_o  (arith_res)
  );

  // shared combinational values
  always_comb begin
    dx_c     = sat_sub(x_q, mean_q);
    e_c      = sat_sub(x_q, mean_q);
    ssd_new  = sat_add(ssd_q, signed_of(dx_q[63] ^ e_c[63], sat_hi(arith_res)));
    var_go   = (n_q > 32'd1) && (t_q != 64'd0) && !ssd_new[63] && (ssd_new != 64'd0);
    hval     = sat_hi(arith_res);
    out_free = !m_valid_q || m_axis_tready;
    fin_load = (state_q == ST_FIN) && out_free;
    minn     = (min_samples_q < 32'd2) ? 32'd2 : min_samples_q;
    conv     = !(tol_q[63] || (hw_q > tol_q) || (n_q < minn) ||
                 (t_q < {16'd0, min_time_q}));
    t_sum    = {1'b0, t_q} + {17'd0, dt_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (s_axis_tvalid) state_d = ST_RD;
      ST_RD:    state_d = ST_LD;
      ST_LD:    state_d = enabled_q ? ST_M1_GO : ST_FIN;
      ST_M1_GO: state_d = ST_M1;
      ST_M1:    if (arith_done) state_d = (t_q != 64'd0) ? ST_D1_GO : ST_M2_GO;
      ST_D1_GO: state_d = ST_D1;
      ST_D1:    if (arith_done) state_d = ST_M2_GO;
      ST_M2_GO: state_d = ST_M2;
      ST_M2:    if (arith_done) state_d = var_go ? ST_D2_GO : ST_S1_GO;
      ST_D2_GO: state_d = ST_D2;
      ST_D2:    if (arith_done) state_d = ST_M3_GO;
      ST_M3_GO: state_d = ST_M3;
      ST_M3:    if (arith_done) state_d = ST_D3_GO;
      ST_D3_GO: state_d = ST_D3;
      ST_D3:    if (arith_done) state_d = ST_S1_GO;
      ST_S1_GO: state_d = ST_S1;
      ST_S1:    if (arith_done) state_d = ST_D4_GO;
      ST_D4_GO: state_d = ST_D4;
      ST_D4:    if (arith_done) state_d = ST_S2_GO;
      ST_S2_GO: state_d = ST_S2;
      ST_S2:    if (arith_done) state_d = ST_M4_GO;
      ST_M4_GO: state_d = ST_M4;
      ST_M4:    if (arith_done) state_d = relative_q ? ST_M5_GO : ST_FIN;
      ST_M5_GO: state_d = ST_M5;
      ST_M5:    if (arith_done) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: unit requests and operands
  always_comb begin
    req.start = 1'b0;
    req.op    = OP_MUL;
    arith_a   = 128'd0;
    arith_b   = 64'd0;
    case (state_q)
      ST_M1_GO: begin
        req.start = 1'b1;
        arith_a   = {80'd0, dt_q};
        arith_b   = mag(dx_c);
      end
      ST_D1_GO: begin
        req = '{start: 1'b1, op: OP_DIV};
        arith_a = prod_q;
        arith_b = t_q;
      end
      ST_M2_GO: begin
        req.start = 1'b1;
        arith_a   = {64'd0, p1_q};
        arith_b   = mag(e_c);
      end
      ST_D2_GO: begin
        req = '{start: 1'b1, op: OP_DIV};
        arith_a = {32'd0, ssd_q, 32'd0};
        arith_b = t_q;
      end
      ST_M3_GO: begin
        req.start = 1'b1;
        arith_a   = {64'd0, var_q};
        arith_b   = {32'd0, n_q};
      end
      ST_D3_GO: begin
        req = '{start: 1'b1, op: OP_DIV};
        arith_a = prod_q;
        arith_b = {32'd0, n_q - 32'd1};
      end
      ST_S1_GO, ST_S2_GO: begin
        req = '{start: 1'b1, op: OP_SQRT};
        arith_a = {32'd0, var_q, 32'd0};
      end
      ST_D4_GO: begin
        req = '{start: 1'b1, op: OP_DIV};
        arith_a = {64'd0, var_q};
        arith_b = (n_q == 32'd0) ? 64'd1 : {32'd0, n_q};
      end
      ST_M4_GO: begin
        req.start = 1'b1;
        arith_a   = {80'd0, quantile_q};
        arith_b   = se_q;
      end
      ST_M5_GO: begin
        req.start = 1'b1;
        arith_a   = {80'd0, target_q};
        arith_b   = mag(mean_q);
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  // datapath register updates
  always_comb begin
    n_d    = n_q;
    t_d    = t_q;
    mean_d = mean_q;
    ssd_d  = ssd_q;
    dx_d   = dx_q;
    p1_d   = p1_q;
    var_d  = var_q;
    std_d  = std_q;
    se_d   = se_q;
    hw_d   = hw_q;
    tol_d  = tol_q;
    prod_d = prod_q;
    flag_d = flag_q;
    case (state_q)
      ST_LD: begin
        n_d    = valid_q[ch_q] ? rd_q[223:192] : 32'd0;
        t_d    = valid_q[ch_q] ? rd_q[191:128] : 64'd0;
        mean_d = valid_q[ch_q] ? rd_q[127:64]  : 64'd0;
        ssd_d  = valid_q[ch_q] ? rd_q[63:0]    : 64'd0;
      end
      ST_M1_GO: dx_d = dx_c;
      ST_M1: if (arith_done) begin
        p1_d   = hval;
        prod_d = arith_res;
      end
      ST_D1: if (arith_done) mean_d = sat_add(mean_q, signed_of(dx_q[63], sat_lo(arith_res)));
      ST_M2: if (arith_done) begin
        ssd_d = ssd_new;
        if (!var_go) var_d = 64'd0;
      end
      ST_D2: if (arith_done) var_d = sat_lo(arith_res);
      ST_M3: if (arith_done) prod_d = arith_res;
      ST_D3: if (arith_done) var_d = sat_lo(arith_res);
      ST_S1: if (arith_done) std_d = arith_res[63:0];
      ST_D4: if (arith_done) var_d = arith_res[63:0];
      ST_S2: if (arith_done) se_d = arith_res[63:0];
      ST_M4: if (arith_done) begin
        hw_d  = hval[63] ? SMAX : hval;
        tol_d = {16'd0, target_q};
      end
      ST_M5: if (arith_done) tol_d = signed_of(mean_q[63], hval);
      ST_FIN: if (out_free && enabled_q) flag_d = first_q ? conv : (flag_q & conv);
      default: begin
        n_d = n_q;
      end
    endcase
  end

  // result beat and statistics write-back
  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    mem_we    = fin_load && enabled_q;
    mem_wdata = {(n_q == 32'hFFFF_FFFF) ? n_q : n_q + 32'd1,
                 t_sum[64] ? {64{1'b1}} : t_sum[63:0],
                 mean_q, ssd_q};
    if (fin_load) begin
      m_valid_d = 1'b1;
      if (enabled_q) begin
        m_data_d = {2'b00, hw_q[62:0], std_q[62:0], mean_q};
        m_user_d = {flag_d, conv};
      end else begin
        m_data_d = {128'd0, mean_q};
        m_user_d = 2'b11;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      flag_q        <= 1'b1;
      m_valid_q     <= 1'b0;
      valid_q       <= '0;
      enabled_q     <= 1'b1;
      target_q      <= 48'd0;
      relative_q    <= 1'b1;
      min_samples_q <= 32'd500;
      min_time_q    <= 48'd0;
      quantile_q    <= 48'd8418135900;
    end else begin
      state_q   <= state_d;
      flag_q    <= flag_d;
      m_valid_q <= m_valid_d;
      if (mem_we) valid_q[ch_q] <= 1'b1;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ENABLED:     enabled_q     <= cfg_wdata_i[0];
          CFG_TARGET:      target_q      <= cfg_wdata_i;
          CFG_RELATIVE:    relative_q    <= cfg_wdata_i[0];
          CFG_MIN_SAMPLES: min_samples_q <= cfg_wdata_i[31:0];
          CFG_MIN_TIME:    min_time_q    <= cfg_wdata_i;
          CFG_QUANTILE:    quantile_q    <= cfg_wdata_i;
          default:         enabled_q     <= enabled_q;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      ch_q    <= ch_wrap(s_axis_tdata[2:0]);
      x_q     <= s_axis_tdata[66:3];
      dt_q    <= s_axis_tdata[114:67];
      first_q <= s_axis_tuser;
    end
    n_q      <= n_d;
    t_q      <= t_d;
    mean_q   <= mean_d;
    ssd_q    <= ssd_d;
    dx_q     <= dx_d;
    p1_q     <= p1_d;
    var_q    <= var_d;
    std_q    <= std_d;
    se_q     <= se_d;
    hw_q     <= hw_d;
    tol_q    <= tol_d;
    prod_q   <= prod_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  // statistics memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[ch_q] <= mem_wdata;
    rd_q <= mem[ch_q];
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
  a_accept_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == ST_RD))
    else $error("accepted beat did not start a channel read");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arith_done |-> (state_q == ST_M1 || state_q == ST_D1 || state_q == ST_M2 ||
                    state_q == ST_D2 || state_q == ST_M3 || state_q == ST_D3 ||
                    state_q == ST_S1 || state_q == ST_D4 || state_q == ST_S2 ||
                    state_q == ST_M4 || state_q == ST_M5))
    else $error("arithmetic result arrived outside a wait state");

  a_write_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> m_axis_tvalid)
    else $error("statistics written without a result beat");
`endif

endmodule

// File: tb/tb_weighted_running_confidence_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_running_confidence_monitor
// Self-checking bench: directed and random samples on all channels, a
// behavioral predictor of mean, deviation, half-width and convergence
// verdicts, and random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_weighted_running_confidence_monitor;
  import wrcm_pkg::*;

  localparam int NCH      = 8;
  localparam int WDOG_MAX = 200000;
  localparam logic [63:0] U64MAX = {64{1'b1}};
  localparam logic [47:0] M48 = {48{1'b1}};

  typedef struct packed {
    logic        first;
    logic [47:0] dt;
    logic [63:0] x;
    logic [2:0]  ch;
  } sample_t;

  typedef struct packed {
    logic        step_conv;
    logic        ch_conv;
    logic [62:0] hw;
    logic [62:0] sd;
    logic [63:0] mean;
  } stats_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [2:0] cfg_idx_i;
  logic [47:0] cfg_wdata_i;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [119:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;

  weighted_running_confidence_monitor #(.CHANNELS(NCH)) i_dut (.*);

  // predictor state: configuration and per-channel statistics
  logic        c_en, c_rel;
  logic [47:0] c_target, c_mintime, c_quant;
  logic [31:0] c_minn;
  logic [31:0] st_n   [NCH];
  logic [63:0] st_t   [NCH];
  logic [63:0] st_mu  [NCH];
  logic [63:0] st_ssd [NCH];
  logic        st_and;

  sample_t pending_samples[$];
  stats_t  expected_stats[$];
  int      n_errors;
  int      send_idle_pct, recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // restoring division of a 128-bit dividend; d nonzero
  function automatic logic [127:0] div128(logic [127:0] num, logic [63:0] d);
    logic [127:0] q;
    logic [128:0] rem;
    q = '0; rem = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[127:0], num[i]};
      if (rem >= {65'd0, d}) begin
        rem = rem - {65'd0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] isqrt128(logic [127:0] v);
    logic [63:0] r, c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= v) r = c;
    end
    return r;
  endfunction

  function automatic logic [63:0] clamp_lo(logic [127:0] v);
    return (v[127:64] != 0) ? U64MAX : v[63:0];
  endfunction

  function automatic logic [63:0] clamp_q32(logic [127:0] v);
    return (v[127:96] != 0) ? U64MAX : v[95:32];
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] to_signed(logic neg, logic [63:0] m);
    if (!neg) return (m > SMAX) ? SMAX : m;
    return (m > SMIN) ? SMIN : -m;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
    return r;
  endfunction

  function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? SMIN : SMAX;
    return r;
  endfunction

  // one sample through the running statistics
  function automatic stats_t update_stats(sample_t s);
    stats_t o;
    logic [63:0] n, t, mu, dx, mdx, e, p, ssd, var_q, sd, se, hw, tol, r, minn, tn;
    logic [127:0] prod;
    logic conv;
    int ch;
    ch = s.ch % NCH;
    n = {32'd0, st_n[ch]};
    t = st_t[ch];
    mu = st_mu[ch];
    if (!c_en) begin
      o = '{step_conv: 1'b1, ch_conv: 1'b1, hw: '0, sd: '0, mean: mu};
      return o;
    end
    dx = sub_sat(s.x, mu);
    mdx = abs64(dx);
    prod = {80'd0, s.dt} * {64'd0, mdx};
    if (t != 0) mu = add_sat(mu, to_signed(dx[63], clamp_lo(div128(prod, t))));
    e = sub_sat(s.x, mu);
    p = clamp_q32(prod);
    p = clamp_q32({64'd0, p} * {64'd0, abs64(e)});
    ssd = add_sat(st_ssd[ch], to_signed(dx[63] != e[63], p));
    var_q = '0;
    if (n > 1 && t != 0 && !ssd[63] && ssd != 0) begin
      r = clamp_lo(div128({32'd0, ssd, 32'd0}, t));
      var_q = clamp_lo(div128({64'd0, r} * {64'd0, n}, n - 1));
    end
    sd = isqrt128({32'd0, var_q, 32'd0});
    se = isqrt128({32'd0, var_q / ((n == 0) ? 64'd1 : n), 32'd0});
    hw = clamp_q32({80'd0, c_quant} * {64'd0, se});
    if (hw > SMAX) hw = SMAX;
    if (c_rel) tol = to_signed(mu[63], clamp_q32({80'd0, c_target} * {64'd0, abs64(mu)}));
    else tol = {16'd0, c_target};
    minn = (c_minn < 2) ? 64'd2 : {32'd0, c_minn};
    conv = !(tol[63] || hw > tol || n < minn || t < {16'd0, c_mintime});
    if (st_n[ch] != '1) st_n[ch] = st_n[ch] + 1;
    tn = t + {16'd0, s.dt};
    st_t[ch] = (tn < t) ? U64MAX : tn;
    st_mu[ch] = mu;
    st_ssd[ch] = ssd;
    st_and = s.first ? conv : (st_and & conv);
    o = '{step_conv: st_and, ch_conv: conv, hw: hw[62:0], sd: sd[62:0], mean: mu};
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    n_errors++;
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------- driver
  // Accept seen at the rising edge: the sample leaves the queue and is
  // predicted there. The next beat is placed at the falling edge.
  logic beat_taken;
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      expected_stats.push_back(update_stats(pending_samples.pop_front()));
      beat_taken <= 1'b1;
    end else begin
      beat_taken <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || beat_taken)) begin
      if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_t s;
        s = pending_samples[0];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, s.dt, s.x, s.ch};
        s_axis_tuser  <= s.first;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected beat", m_axis_tdata[63:0], '0);
      end else begin
        stats_t w;
        w = expected_stats.pop_front();
        if (m_axis_tdata[63:0] !== w.mean)
          report_mismatch("running_mean_out", m_axis_tdata[63:0], w.mean);
        if (m_axis_tdata[126:64] !== w.sd)
          report_mismatch("std_deviation", {1'b0, m_axis_tdata[126:64]}, {1'b0, w.sd});
        if (m_axis_tdata[189:127] !== w.hw)
          report_mismatch("confidence_halfwidth", {1'b0, m_axis_tdata[189:127]},
                          {1'b0, w.hw});
        if (m_axis_tuser[0] !== w.ch_conv)
          report_mismatch("channel_converged", {63'd0, m_axis_tuser[0]}, {63'd0, w.ch_conv});
        if (m_axis_tuser[1] !== w.step_conv)
          report_mismatch("step_converged", {63'd0, m_axis_tuser[1]}, {63'd0, w.step_conv});
      end
    end
  end

  // watchdog: cycles without any accepted beat
  int idle_cycles;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("watchdog: no progress");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_stats.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLED:     c_en = val[0];
      CFG_TARGET:      c_target = val;
      CFG_RELATIVE:    c_rel = val[0];
      CFG_MIN_SAMPLES: c_minn = val[31:0];
      CFG_MIN_TIME:    c_mintime = val;
      CFG_QUANTILE:    c_quant = val;
      default: ;
    endcase
  endtask

  task automatic push_sample(int ch, logic [63:0] x, logic [47:0] dt, logic first);
    sample_t s;
    s = '{first: first, dt: dt, x: x, ch: ch[2:0]};
    pending_samples.push_back(s);
  endtask

  function automatic logic [63:0] rand_value(int sel);
    case (sel)
      0: return {$urandom, $urandom};
      1: return {{30{1'b0}}, 2'b01, $urandom};                 // near 1.0
      2: return {{29{1'($urandom_range(1))}}, 3'($urandom), $urandom};
      default: return {32'd100, $urandom} + {32'($urandom_range(7)), 32'd0};
    endcase
  endfunction

  function automatic logic [47:0] rand_dt();
    case ($urandom_range(5))
      0: return 48'({$urandom, $urandom});
      1: return '0;
      default: return {14'd0, 2'($urandom_range(3)), $urandom};
    endcase
  endfunction

  task automatic random_phase(int count, int idle, int stall);
    wait_drained();
    send_idle_pct = idle; recv_stall_pct = stall;
    for (int i = 0; i < count; i++)
      push_sample($urandom_range(7), rand_value($urandom_range(3)), rand_dt(),
                  ($urandom_range(3) == 0));
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    send_idle_pct = 0; recv_stall_pct = 0;
    n_errors = 0;
    c_en = 1'b1; c_target = '0; c_rel = 1'b1; c_minn = 32'd500;
    c_mintime = '0; c_quant = 48'd8418135900;
    for (int i = 0; i < NCH; i++) begin
      st_n[i] = '0; st_t[i] = '0; st_mu[i] = '0; st_ssd[i] = '0;
    end
    st_and = 1'b1;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset config, extremes of value and time step
    push_sample(0, 64'h0000_0001_0000_0000, 48'h1_0000_0000, 1'b1);
    push_sample(0, 64'h0000_0003_0000_0000, 48'h1_0000_0000, 1'b0);
    push_sample(0, SMAX, M48, 1'b0);
    push_sample(0, SMIN, M48, 1'b0);
    push_sample(1, SMIN, '0, 1'b1);
    push_sample(1, '0, '0, 1'b0);
    push_sample(7, SMAX, 48'd1, 1'b0);
    push_sample(7, 64'hFFFF_FFFF_FFFF_FFFF, M48, 1'b1);
    wait_drained();

    // absolute tolerance, tiny minimums: convergence possible
    write_reg(CFG_RELATIVE, 48'd0);
    write_reg(CFG_TARGET, M48);
    write_reg(CFG_MIN_SAMPLES, 48'd0);
    write_reg(CFG_MIN_TIME, 48'd0);
    write_reg(CFG_QUANTILE, 48'd1);
    for (int i = 0; i < 6; i++)
      push_sample(2, {32'd5 + 32'(i), 32'd0}, 48'h1_0000_0000, i == 0);
    push_sample(3, 64'd1, 48'h1_0000_0000, 1'b0);
    wait_drained();

    // relative mode with a negative mean never converges; disabled block
    write_reg(CFG_RELATIVE, 48'd1);
    write_reg(CFG_MIN_SAMPLES, 48'd1);
    write_reg(CFG_QUANTILE, M48);
    for (int i = 0; i < 4; i++)
      push_sample(4, -64'({32'd7, 32'd0}) + i, 48'h8000_0000, i == 0);
    wait_drained();
    write_reg(CFG_ENABLED, 48'd0);
    push_sample(4, SMAX, M48, 1'b1);
    push_sample(2, 64'd0, 48'd0, 1'b0);
    wait_drained();
    write_reg(CFG_ENABLED, 48'd1);
    write_reg(CFG_MIN_SAMPLES, 48'hFFFF_FFFF);
    write_reg(CFG_MIN_TIME, M48);
    push_sample(2, 64'd0, 48'd3, 1'b1);

    // random phases across idle/stall mixes and config settings
    random_phase(150, 0, 0);
    write_reg(CFG_MIN_SAMPLES, 48'd2);
    write_reg(CFG_MIN_TIME, 48'h1_0000_0000);
    write_reg(CFG_RELATIVE, 48'd0);
    write_reg(CFG_TARGET, 48'h10_0000_0000);
    write_reg(CFG_QUANTILE, 48'd8418135900);
    random_phase(130, 87, 0);
    write_reg(CFG_RELATIVE, 48'd1);
    write_reg(CFG_TARGET, 48'h8000_0000);
    random_phase(130, 0, 87);
    write_reg(CFG_TARGET, '0);
    write_reg(CFG_MIN_TIME, '0);
    random_phase(130, 22, 22);
    write_reg(CFG_RELATIVE, 48'd0);
    write_reg(CFG_TARGET, 48'hFFFF_0000_0000);
    write_reg(CFG_MIN_SAMPLES, 48'd3);
    random_phase(130, 0, 0);
    wait_drained();

    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/wrcm_pkg.sv
hdl/wrcm_arith.sv
hdl/weighted_running_confidence_monitor.sv
tb/tb_weighted_running_confidence_monitor.sv
